// ===== rtl/phh_pkg.sv =====
`timescale 1ns / 1ps
package phh_pkg;
   localparam logic [1:0] ACT_FILL  = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   // action three is handled as a read
   localparam logic [1:0] ACT_READ_ALT = 2'd3;

   localparam logic [2:0] ST_COUNTED = 3'd0;
   localparam logic [2:0] ST_BAD_WIN = 3'd1;
   localparam logic [2:0] ST_BAD_HEAD = 3'd2;
   localparam logic [2:0] ST_X_OUT   = 3'd3;
   localparam logic [2:0] ST_Y_OUT   = 3'd4;
   localparam logic [2:0] ST_SAT     = 3'd5;
   localparam logic [2:0] ST_CLEARED = 3'd6;
   localparam logic [2:0] ST_READ    = 3'd7;

   localparam logic [2:0] REG_WINDOWS = 3'd0;
   localparam logic [2:0] REG_HEADS   = 3'd1;
   localparam logic [2:0] REG_ACROSS  = 3'd2;
   localparam logic [2:0] REG_DOWN    = 3'd3;
   localparam logic [2:0] REG_EDGE_X  = 3'd4;
   localparam logic [2:0] REG_EDGE_Y  = 3'd5;
   localparam logic [2:0] REG_PIX_W   = 3'd6;
   localparam logic [2:0] REG_PIX_H   = 3'd7;

   localparam int QUOT_BITS = 33;

   typedef struct packed {
      logic [2:0]  window_count;
      logic [2:0]  head_count;
      logic [7:0]  pixels_across;
      logic [7:0]  pixels_down;
      logic [31:0] low_edge_across;
      logic [31:0] low_edge_down;
      logic [15:0] pixel_width;
      logic [15:0] pixel_height;
   } cfg_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [15:0] divisor;
   } div_req_type;
endpackage

// ===== rtl/phh_divider.sv =====
`timescale 1ns / 1ps
module phh_divider
   import phh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [32:0] quotient
);
   logic [32:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [17:0] trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial = {rem_ff, quot_ff[32]} - {2'b0, dvs_ff};
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quot_in = req.dividend;
         rem_in = '0;
         cnt_in = 6'(QUOT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quot_in = {quot_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quot_ff[32]};
            quot_in = {quot_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (req.start) dvs_ff <= req.divisor;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

// ===== rtl/phh_bin_store.sv =====
`timescale 1ns / 1ps
module phh_bin_store #(
   parameter int ADDR_BITS = 18,
   parameter int DATA_BITS = 16,
   parameter int EPOCH_BITS = 8
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [DATA_BITS-1:0]  rd_data,
   output logic [EPOCH_BITS-1:0] rd_epoch,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [DATA_BITS-1:0]  wr_data,
   input  logic [EPOCH_BITS-1:0] wr_epoch
);
   logic [DATA_BITS+EPOCH_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS+EPOCH_BITS-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {wr_epoch, wr_data};
      if (rd_en) q_ff <= mem[rd_addr];
   end

   assign rd_data = q_ff[DATA_BITS-1:0];
   assign rd_epoch = q_ff[DATA_BITS+EPOCH_BITS-1:DATA_BITS];
endmodule

// ===== rtl/projection_hit_histogrammer_top.sv =====
`timescale 1ns / 1ps
// Bins detector hits into per-window, per-head count images.
// req channel: one transfer per item (fill, clear or read). rsp channel:
// one result transfer per item. csr channel: register index and data, to be
// written only while the block is idle; the block does not enforce this.
// One item is handled at a time. A fill computes column and row in turn with a
// shared restoring divider, then reads, increments and writes back its bin in
// the bin memory; a hit outside in x ends after the column division, one
// outside in y after the row division. A read looks up its bin; a rejected
// item and a clear go straight to their result.
// Unless a sweep follows, the next item can be taken the cycle after the result transfer.
// Clear is done by bumping an epoch tag stored beside each count; a bin
// whose tag differs from the current epoch reads as zero. When the epoch
// wraps, a sweep of all 2**(address bits) bins, 262144 at the default sizes,
// rewrites them to zero, one bin a cycle.
// Reset starts such a sweep too: the block takes no item until the sweep
// ends, while csr writes are taken as ever.
// The result stays in the rsp register while rsp_tready is low, and no
// new item is taken until it has been transferred.
module projection_hit_histogrammer_top
   import phh_pkg::*;
#(
   parameter int MAX_WINDOWS = 4,
   parameter int MAX_HEADS = 4,
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS = 128,
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // window[2:0], head[5:3], coord_across[37:6], coord_down[69:38],
   // read_column[76:70], read_row[83:77], zero fill
   input  logic [87:0]  req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // bin_count[15:0], window_head_max[31:16], bin_column[38:32],
   // bin_row[45:39], zero fill
   output logic [47:0]  rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   localparam int WB = $clog2(MAX_WINDOWS) > 0 ? $clog2(MAX_WINDOWS) : 1;
   localparam int HB = $clog2(MAX_HEADS) > 0 ? $clog2(MAX_HEADS) : 1;
   localparam int CB = $clog2(MAX_COLUMNS);
   localparam int RB = $clog2(MAX_ROWS);
   localparam int AB = WB + HB + RB + CB;
   localparam int MB = WB + HB;
   localparam int EB = 8;
   localparam logic [COUNT_BITS-1:0] CEIL = '1;

   localparam logic [2:0] S_SWEEP = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIVX  = 3'd2;
   localparam logic [2:0] S_DIVY  = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;
   localparam logic [2:0] S_MOD   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   cfg_type cfg_ff;
   logic [2:0] state_ff, state_in;
   logic [AB-1:0] sweep_ff;
   logic [EB-1:0] epoch_ff;
   logic [COUNT_BITS-1:0] max_ff [2**MB];

   logic [1:0] act_ff;
   logic [2:0] w_ff, h_ff;
   logic [31:0] y_ff;
   logic dx_neg_ff;
   logic [CB-1:0] col_ff;
   logic [RB-1:0] row_ff;
   logic [MB-1:0] mi_ff;

   logic [2:0] st_ff;
   logic [15:0] cnt_o_ff, max_o_ff;
   logic [6:0] col_o_ff, row_o_ff;
   logic out_v_ff;

   div_req_type dreq;
   logic d_done;
   logic [32:0] d_q;
   logic [COUNT_BITS-1:0] rd_data;
   logic [EB-1:0] rd_epoch;
   logic mem_rd, mem_wr;
   logic [AB-1:0] mem_wa, rd_addr;
   logic [COUNT_BITS-1:0] mem_wd;
   logic [EB-1:0] mem_we;

   logic [4:0] wcnt, hcnt;
   logic [10:0] cols, rows;
   logic acc;
   logic win_bad, head_bad, req_ok, col_out, row_out;
   logic [MB-1:0] req_mi;
   logic [32:0] dx, dy;
   logic [COUNT_BITS-1:0] cur, nxt;

   assign wcnt = (5'(cfg_ff.window_count) > 5'(MAX_WINDOWS)) ? 5'(MAX_WINDOWS)
                 : 5'(cfg_ff.window_count);
   assign hcnt = (5'(cfg_ff.head_count) > 5'(MAX_HEADS)) ? 5'(MAX_HEADS)
                 : 5'(cfg_ff.head_count);
   assign cols = (11'(cfg_ff.pixels_across) > 11'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS)
                 : 11'(cfg_ff.pixels_across);
   assign rows = (11'(cfg_ff.pixels_down) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS)
                 : 11'(cfg_ff.pixels_down);

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign acc = req_tvalid && req_tready;

   assign win_bad = 5'(req_tdata[2:0]) >= wcnt;
   assign head_bad = 5'(req_tdata[5:3]) >= hcnt;
   assign req_ok = (req_tuser != ACT_CLEAR) && !win_bad && !head_bad;
   assign col_out = 11'(req_tdata[76:70]) >= cols;
   assign row_out = 11'(req_tdata[83:77]) >= rows;
   assign req_mi = {WB'(req_tdata[2:0]), HB'(req_tdata[5:3])};

   assign dx = {req_tdata[37], req_tdata[37:6]} - {cfg_ff.low_edge_across[31],
                cfg_ff.low_edge_across};
   assign dy = {y_ff[31], y_ff} - {cfg_ff.low_edge_down[31], cfg_ff.low_edge_down};

   assign cur = (rd_epoch == epoch_ff) ? rd_data : '0;
   assign nxt = (cur == CEIL) ? cur : cur + 1'b1;
   assign rd_addr = {WB'(w_ff), HB'(h_ff), row_ff, col_ff};

   always_comb begin
      dreq = '0;
      if (acc && req_tuser == ACT_FILL) begin
         dreq.start = 1'b1;
         dreq.dividend = dx;
         dreq.divisor = cfg_ff.pixel_width;
      end else if (state_ff == S_DIVX && d_done) begin
         dreq.start = 1'b1;
         dreq.dividend = dy;
         dreq.divisor = cfg_ff.pixel_height;
      end
   end

   always_comb begin
      mem_wr = 1'b0;
      mem_wa = rd_addr;
      mem_wd = nxt;
      mem_we = epoch_ff;
      if (state_ff == S_SWEEP) begin
         mem_wr = 1'b1;
         mem_wa = sweep_ff;
         mem_wd = '0;
      end else if (state_ff == S_MOD && act_ff == ACT_FILL) begin
         mem_wr = 1'b1;
      end
   end
   assign mem_rd = (state_ff == S_RD);

   phh_divider u_div (
      .clock(clock), .reset(reset), .req(dreq), .done(d_done), .quotient(d_q)
   );

   phh_bin_store #(.ADDR_BITS(AB), .DATA_BITS(COUNT_BITS), .EPOCH_BITS(EB)) u_mem (
      .clock(clock), .rd_en(mem_rd), .rd_addr(rd_addr), .rd_data(rd_data),
      .rd_epoch(rd_epoch), .wr_en(mem_wr), .wr_addr(mem_wa), .wr_data(mem_wd),
      .wr_epoch(mem_we)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         epoch_ff <= '0;
         out_v_ff <= 1'b0;
         cfg_ff.window_count <= 3'd1;
         cfg_ff.head_count <= 3'd1;
         cfg_ff.pixels_across <= 8'd128;
         cfg_ff.pixels_down <= 8'd128;
         cfg_ff.low_edge_across <= '0;
         cfg_ff.low_edge_down <= '0;
         cfg_ff.pixel_width <= 16'd256;
         cfg_ff.pixel_height <= 16'd256;
         for (int i = 0; i < 2**MB; i++) max_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_WINDOWS: cfg_ff.window_count <= csr_data[2:0];
               REG_HEADS:   cfg_ff.head_count <= csr_data[2:0];
               REG_ACROSS:  cfg_ff.pixels_across <= csr_data[7:0];
               REG_DOWN:    cfg_ff.pixels_down <= csr_data[7:0];
               REG_EDGE_X:  cfg_ff.low_edge_across <= csr_data;
               REG_EDGE_Y:  cfg_ff.low_edge_down <= csr_data;
               REG_PIX_W:   cfg_ff.pixel_width <= csr_data[15:0];
               REG_PIX_H:   cfg_ff.pixel_height <= csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
         state_ff <= state_in;
         if (state_ff == S_SWEEP) sweep_ff <= sweep_ff + 1'b1;
         if (acc && req_tuser == ACT_CLEAR) begin
            epoch_ff <= epoch_ff + 1'b1;
            sweep_ff <= '0;
         end
         if (state_ff == S_MOD && act_ff == ACT_FILL && nxt > max_ff[mi_ff])
            max_ff[mi_ff] <= nxt;
         if (state_ff == S_OUT) out_v_ff <= 1'b1;
         else if (acc && req_tuser == ACT_CLEAR) out_v_ff <= 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SWEEP: if (sweep_ff == '1) state_in = S_IDLE;
         S_IDLE: begin
            if (acc) begin
               if (req_tuser == ACT_CLEAR)
                  state_in = (epoch_ff == '1) ? S_SWEEP : S_IDLE;
               else if (win_bad || head_bad) state_in = S_OUT;
               else if (req_tuser == ACT_FILL) state_in = S_DIVX;
               else if (col_out || row_out) state_in = S_OUT;
               else state_in = S_RD;
            end
         end
         S_DIVX: begin
            if (d_done) begin
               if (dx_neg_ff || cfg_ff.pixel_width == '0 || d_q >= 33'(cols))
                  state_in = S_OUT;
               else state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (d_done) begin
               if (dy[32] || cfg_ff.pixel_height == '0 || d_q >= 33'(rows))
                  state_in = S_OUT;
               else state_in = S_RD;
            end
         end
         S_RD:  state_in = S_MOD;
         S_MOD: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // per-item datapath and result register
   always_ff @(posedge clock) begin
      if (acc) begin
         act_ff <= req_tuser;
         w_ff <= req_tdata[2:0];
         h_ff <= req_tdata[5:3];
         y_ff <= req_tdata[69:38];
         dx_neg_ff <= dx[32];
         mi_ff <= req_mi;
         col_ff <= CB'(req_tdata[76:70]);
         row_ff <= RB'(req_tdata[83:77]);
         cnt_o_ff <= '0;
         if (req_ok) max_o_ff <= 16'(max_ff[req_mi]);
         else max_o_ff <= '0;
         if (req_ok && req_tuser != ACT_FILL) begin
            col_o_ff <= req_tdata[76:70];
            row_o_ff <= req_tdata[83:77];
         end else begin
            col_o_ff <= '0;
            row_o_ff <= '0;
         end
         if (req_tuser == ACT_CLEAR) st_ff <= ST_CLEARED;
         else if (win_bad) st_ff <= ST_BAD_WIN;
         else if (head_bad) st_ff <= ST_BAD_HEAD;
         else if (req_tuser != ACT_FILL) begin
            if (col_out) st_ff <= ST_X_OUT;
            else if (row_out) st_ff <= ST_Y_OUT;
            else st_ff <= ST_READ;
         end
      end
      if (state_ff == S_DIVX && d_done) begin
         if (dx_neg_ff || cfg_ff.pixel_width == '0 || d_q >= 33'(cols))
            st_ff <= ST_X_OUT;
         else begin
            col_ff <= d_q[CB-1:0];
            col_o_ff <= 7'(d_q[CB-1:0]);
         end
      end
      if (state_ff == S_DIVY && d_done) begin
         if (dy[32] || cfg_ff.pixel_height == '0 || d_q >= 33'(rows))
            st_ff <= ST_Y_OUT;
         else row_ff <= d_q[RB-1:0];
      end
      if (state_ff == S_MOD) begin
         row_o_ff <= 7'(row_ff);
         cnt_o_ff <= (act_ff == ACT_FILL) ? 16'(nxt) : 16'(cur);
         if (act_ff == ACT_FILL) begin
            st_ff <= (cur == CEIL) ? ST_SAT : ST_COUNTED;
            max_o_ff <= (nxt > max_ff[mi_ff]) ? 16'(nxt) : 16'(max_ff[mi_ff]);
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser = st_ff;
   assign rsp_tdata = {2'b0, row_o_ff, col_o_ff, max_o_ff, cnt_o_ff};

`ifndef NO_ASSERTIONS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("item taken with result pending");
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> !req_tready) else $error("item taken during sweep");
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      mem_wr && state_ff == S_MOD |-> $past(mem_rd)) else $error("write without read");
`endif
endmodule

// ===== tb/phh_checker.sv =====
`timescale 1ns / 1ps
module phh_checker
   import phh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [87:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           fail_count,
   output int           pending
);
   localparam int NUM_WIN = 4;
   localparam int NUM_HEAD = 4;
   localparam int NUM_COL = 128;
   localparam int NUM_ROW = 128;
   localparam int COUNT_CEIL = 65535;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] count;
      logic [15:0] peak;
      logic [6:0]  column;
      logic [6:0]  row;
   } bin_result_type;

   cfg_type        setup;
   logic [15:0]    image_counts [int];
   logic [15:0]    peak_counts [NUM_WIN*NUM_HEAD];
   bin_result_type expected_bins [$];

   assign pending = expected_bins.size();

   // floor((coord - lo) / size), rejected outside [0, lim)
   function automatic bit locate_bin(input longint coord, input longint lo,
                                     input longint size, input longint lim,
                                     output int idx);
      longint diff;
      diff = coord - lo;
      idx = 0;
      if (size == 0 || diff < 0) return 0;
      if (diff / size >= lim) return 0;
      idx = int'(diff / size);
      return 1;
   endfunction

   function automatic int clamp_to(input int v, input int hi);
      return (v > hi) ? hi : v;
   endfunction

   function automatic bin_result_type bin_hit(input logic [1:0] act, input logic [87:0] d);
      bin_result_type res;
      int w, h, cols, rows, col, row, addr, mi;
      logic [15:0] cur;
      res = '0;
      w = d[2:0];
      h = d[5:3];
      cols = clamp_to(setup.pixels_across, NUM_COL);
      rows = clamp_to(setup.pixels_down, NUM_ROW);
      if (act == ACT_CLEAR) begin
         image_counts.delete();
         res.status = ST_CLEARED;
      end else if (w >= clamp_to(setup.window_count, NUM_WIN)) begin
         res.status = ST_BAD_WIN;
      end else if (h >= clamp_to(setup.head_count, NUM_HEAD)) begin
         res.status = ST_BAD_HEAD;
      end else begin
         mi = w * NUM_HEAD + h;
         res.peak = peak_counts[mi];
         if (act == ACT_FILL) begin
            if (!locate_bin(longint'($signed(d[37:6])), longint'($signed(setup.low_edge_across)),
                            longint'(setup.pixel_width), cols, col)) begin
               res.status = ST_X_OUT;
            end else if (!locate_bin(longint'($signed(d[69:38])),
                                     longint'($signed(setup.low_edge_down)),
                                     longint'(setup.pixel_height), rows, row)) begin
               res.status = ST_Y_OUT;
               res.column = 7'(col);
            end else begin
               addr = ((mi * NUM_ROW) + row) * NUM_COL + col;
               cur = image_counts.exists(addr) ? image_counts[addr] : 16'd0;
               if (cur < COUNT_CEIL) begin
                  cur = cur + 1;
                  res.status = ST_COUNTED;
               end else begin
                  res.status = ST_SAT;
               end
               image_counts[addr] = cur;
               if (cur > peak_counts[mi]) peak_counts[mi] = cur;
               res.count = cur;
               res.peak = peak_counts[mi];
               res.column = 7'(col);
               res.row = 7'(row);
            end
         end else begin
            col = d[76:70];
            row = d[83:77];
            res.column = 7'(col);
            res.row = 7'(row);
            if (col >= cols) begin
               res.status = ST_X_OUT;
            end else if (row >= rows) begin
               res.status = ST_Y_OUT;
            end else begin
               addr = ((mi * NUM_ROW) + row) * NUM_COL + col;
               res.status = ST_READ;
               res.count = image_counts.exists(addr) ? image_counts[addr] : 16'd0;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      bin_result_type want, got;
      if (reset) begin
         setup.window_count <= 3'd1;
         setup.head_count <= 3'd1;
         setup.pixels_across <= 8'd128;
         setup.pixels_down <= 8'd128;
         setup.low_edge_across <= '0;
         setup.low_edge_down <= '0;
         setup.pixel_width <= 16'd256;
         setup.pixel_height <= 16'd256;
         image_counts.delete();
         foreach (peak_counts[i]) peak_counts[i] = '0;
         expected_bins.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WINDOWS: setup.window_count <= csr_data[2:0];
               REG_HEADS:   setup.head_count <= csr_data[2:0];
               REG_ACROSS:  setup.pixels_across <= csr_data[7:0];
               REG_DOWN:    setup.pixels_down <= csr_data[7:0];
               REG_EDGE_X:  setup.low_edge_across <= csr_data;
               REG_EDGE_Y:  setup.low_edge_down <= csr_data;
               REG_PIX_W:   setup.pixel_width <= csr_data[15:0];
               REG_PIX_H:   setup.pixel_height <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_bins.push_back(bin_hit(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.count = rsp_tdata[15:0];
            got.peak = rsp_tdata[31:16];
            got.column = rsp_tdata[38:32];
            got.row = rsp_tdata[45:39];
            if (expected_bins.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_bins.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/projection_hit_histogrammer_top_test.sv =====
`timescale 1ns / 1ps
module projection_hit_histogrammer_top_test;
   import phh_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending;

   int          send_idle = 33;
   int          recv_idle = 65;
   int          hold_left = 0;
   cfg_type     setup;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   projection_hit_histogrammer_top i_dut (.*);

   phh_checker i_checker (.*);

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic put_item(input logic [1:0] act, input int w, input int h,
                           input logic [31:0] x, input logic [31:0] y,
                           input int rc, input int rr);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'b0, 7'(rr), 7'(rc), y, x, 3'(h), 3'(w)};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic apply_setup(input int k);
      // registers change only with nothing in flight
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      repeat (100) @(posedge clock);
      case (k)
         0: setup = '{3'd4, 3'd4, 8'd128, 8'd128, 32'd0, 32'd0, 16'd256, 16'd256};
         1: setup = '{3'd7, 3'd7, 8'd255, 8'd255, 32'h8000_0000, 32'h8000_0000,
                      16'hFFFF, 16'hFFFF};
         2: setup = '{3'd1, 3'd1, 8'd1, 8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1, 16'd1};
         3: setup = '{3'd4, 3'd4, 8'd0, 8'd3, 32'hFFFF_FF00, 32'd50, 16'd0, 16'd0};
         4: setup = '{3'd0, 3'd0, 8'd4, 8'd0, 32'd0, 32'd0, 16'd256, 16'd16};
         default: begin
            setup.window_count = 3'($urandom_range(1, 7));
            setup.head_count = 3'($urandom_range(1, 7));
            setup.pixels_across = 8'($urandom_range(1) ? $urandom_range(1, 8)
                                                       : $urandom_range(1, 255));
            setup.pixels_down = 8'($urandom_range(1) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 255));
            setup.low_edge_across = $urandom_range(1) ? $urandom() : $urandom_range(0, 4000) - 2000;
            setup.low_edge_down = $urandom_range(1) ? $urandom() : $urandom_range(0, 4000) - 2000;
            setup.pixel_width = 16'($urandom_range(1) ? $urandom_range(1, 512)
                                                      : $urandom_range(1, 65535));
            setup.pixel_height = 16'($urandom_range(1) ? $urandom_range(1, 512)
                                                       : $urandom_range(1, 65535));
         end
      endcase
      csr_write(REG_WINDOWS, 32'(setup.window_count));
      csr_write(REG_HEADS, 32'(setup.head_count));
      csr_write(REG_ACROSS, 32'(setup.pixels_across));
      csr_write(REG_DOWN, 32'(setup.pixels_down));
      csr_write(REG_EDGE_X, setup.low_edge_across);
      csr_write(REG_EDGE_Y, setup.low_edge_down);
      csr_write(REG_PIX_W, 32'(setup.pixel_width));
      csr_write(REG_PIX_H, 32'(setup.pixel_height));
   endtask

   // coordinate inside pixel p of an axis, or a little beyond the image
   function automatic logic [31:0] coord_in(input logic [31:0] lo, input logic [15:0] size,
                                            input int lim);
      longint p;
      p = $urandom_range(0, (lim > 0 ? lim : 1) + 1);
      if ($urandom_range(9) == 0) p = -1;
      return 32'(longint'($signed(lo)) + p * size + (size > 0 ? $urandom_range(0, size - 1) : 0));
   endfunction

   task automatic random_item();
      int pick, wc, hc, cols, rows;
      wc = (setup.window_count > 4) ? 4 : setup.window_count;
      hc = (setup.head_count > 4) ? 4 : setup.head_count;
      cols = (setup.pixels_across > 128) ? 128 : setup.pixels_across;
      rows = (setup.pixels_down > 128) ? 128 : setup.pixels_down;
      if (wc == 0) wc = 1;
      if (hc == 0) hc = 1;
      pick = $urandom_range(99);
      if (pick < 78)
         put_item(ACT_FILL, $urandom_range(0, wc - 1), $urandom_range(0, hc - 1),
                  coord_in(setup.low_edge_across, setup.pixel_width, cols),
                  coord_in(setup.low_edge_down, setup.pixel_height, rows), $urandom_range(127),
                  $urandom_range(127));
      else if (pick < 88)
         put_item($urandom_range(1) ? ACT_READ : ACT_READ_ALT, $urandom_range(0, wc - 1),
                  $urandom_range(0, hc - 1), $urandom(), $urandom(), $urandom_range(0, cols),
                  $urandom_range(0, rows));
      else if (pick < 92)
         put_item($urandom_range(1) ? ACT_READ : ACT_READ_ALT, $urandom_range(7),
                  $urandom_range(7), $urandom(), $urandom(), $urandom_range(127),
                  $urandom_range(127));
      else if (pick < 93)
         put_item(ACT_CLEAR, $urandom_range(7), $urandom_range(7), $urandom(), $urandom(),
                  $urandom_range(127), $urandom_range(127));
      else
         put_item(ACT_FILL, $urandom_range(7), $urandom_range(7), $urandom(), $urandom(),
                  $urandom_range(127), $urandom_range(127));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      apply_setup(0);
      // directed: corners, rejects, reads, clear
      put_item(ACT_FILL, 0, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'd32767, 32'd32767, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'd32768, 32'd0, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'hFFFF_FFFF, 32'd0, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'd300, 32'hFFFF_FFFF, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'd300, 32'd32768, 0, 0);
      put_item(ACT_FILL, 1, 2, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      put_item(ACT_FILL, 7, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_FILL, 4, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_FILL, 0, 4, 32'd0, 32'd0, 0, 0);
      put_item(ACT_FILL, 3, 3, 32'd1000, 32'd2000, 0, 0);
      put_item(ACT_READ, 0, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_READ_ALT, 0, 0, 32'd0, 32'd0, 127, 127);
      put_item(ACT_READ, 3, 3, 32'd0, 32'd0, 3, 7);
      put_item(ACT_READ, 7, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_READ, 0, 5, 32'd0, 32'd0, 0, 0);
      put_item(ACT_CLEAR, 0, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_READ, 0, 0, 32'd0, 32'd0, 0, 0);
      put_item(ACT_FILL, 0, 0, 32'd0, 32'd0, 0, 0);
      for (int k = 0; k < 10; k++) begin
         apply_setup(k);
         // long receiver hold-off while items keep coming
         if (k == 0) hold_left = 400;
         if (k == 4) begin
            send_idle = 65;
            recv_idle = 33;
         end else if (k == 7) begin
            send_idle = 0;
            recv_idle = 0;
         end
         for (int n = 0; n < 143; n++) random_item();
      end
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/phh_pkg.sv
rtl/phh_divider.sv
rtl/phh_bin_store.sv
rtl/projection_hit_histogrammer_top.sv
tb/phh_checker.sv
tb/projection_hit_histogrammer_top_test.sv
